[rtl/core/wdbscan_pkg.sv]
// Shared types and constants for the weighted 1-D DBSCAN cluster-mean block.
// Item structs, register indexes and the command/status bundles between
// controller and datapath. No dependencies.
package wdbscan_pkg;

    localparam int DEFAULT_MAX_DISTINCT = 64;
    localparam int VALUE_W    = 16;
    localparam int WEIGHT_W   = 32;
    localparam int MEAN_W     = 24;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS     = 3'd0,
        CFG_MIN_WEIGHT = 3'd1,
        CFG_LOW_PULSE  = 3'd2,
        CFG_RESET_MIN  = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               action;
        logic [VALUE_W-1:0] sample_value;
        logic [VALUE_W-1:0] sample_weight;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] cluster_mean_q8;
        logic              no_clusters;
        logic              store_overflow;
        logic              last_result;
    } out_item_t;

    typedef struct packed {
        logic latch_in;
        logic write_entry;
        logic write_weight;
        logic set_overflow;
        logic clear_overflow;
        logic clear_flags;
        logic cap_center;
        logic clear_acc;
        logic hood_acc;
        logic mark_eval;
        logic set_visited;
        logic clear_pending;
        logic assign_id;
        logic mean_acc;
        logic div_start;
        logic write_mean;
        logic em_clear;
        logic em_cmp;
        logic em_mark;
        logic load_out;
        logic load_none;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic visited;
        logic assigned;
        logic pending;
        logic seed_ok;
        logic core;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

[rtl/core/weighted_1d_dbscan_cluster_means_top.sv]
// Top level of the weighted 1-D DBSCAN cluster-mean block.
// Depends on wdbscan_pkg, wdbscan_ctrl and wdbscan_dp.
//
//   port group   direction  handshake              payload
//   in_*         in         in_valid / in_ready    in_item   (in_item_t)
//   out_*        out        out_valid / out_ready  out_item  (out_item_t)
//   cfg_*        in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. An add item walks the store one held entry after another;
// the store memories' single read port sets this.
// A scan item reads each visited point's neighborhood, walks the store to mark
// neighbors, runs expansion passes, divides each cluster mean on the serial
// divider and searches the means once per emitted result.
// Reset clears control and flags and sets config defaults at once; there is no clearing pass.
// A full output register stalls emission; config writes are taken every cycle.
module weighted_1d_dbscan_cluster_means_top
    import wdbscan_pkg::*;
#(
    parameter int MAX_DISTINCT = DEFAULT_MAX_DISTINCT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_DISTINCT);

    cmd_t             cmd;
    stat_t            stat;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] cid;

    wdbscan_ctrl #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_item.action),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd),
        .addr      (addr),
        .cid       (cid)
    );

    wdbscan_dp #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cmd       (cmd),
        .addr      (addr),
        .cid       (cid),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out || cmd.load_none) |-> (!out_valid || out_ready))
        else $error("result register overwritten while full");

    // An empty scan gives a single, final, zero result
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.no_clusters) |->
            (out_item.last_result && (out_item.cluster_mean_q8 == '0)))
        else $error("no-cluster result malformed");

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");
`endif

endmodule

[rtl/core/wdbscan_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used for the Q8 cluster means; no package dependencies.
module wdbscan_div #(
    parameter int DIVIDEND_W = 31,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/wdbscan_dp.sv]
// Datapath: entry store, scan flags, accumulators, config registers, output item.
// Depends on wdbscan_pkg and wdbscan_div.
module wdbscan_dp
    import wdbscan_pkg::*;
#(
    parameter int MAX_DISTINCT = DEFAULT_MAX_DISTINCT,
    localparam int IDX_W = $clog2(MAX_DISTINCT),
    localparam int CNT_W = $clog2(MAX_DISTINCT + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  cmd_t                  cmd,
    input  logic [IDX_W-1:0]      addr,
    input  logic [IDX_W-1:0]      cid,
    output stat_t                 stat
);

    localparam int SSUM_W = VALUE_W + CNT_W;
    localparam int WSUM_W = WEIGHT_W + CNT_W;
    localparam int DVD_W  = SSUM_W + FRAC_W;

    logic [VALUE_W-1:0]  radius_reg, minw_reg, rmin_reg;
    logic                lpm_reg;
    logic [VALUE_W-1:0]  in_val_reg, in_wgt_reg;

    logic [VALUE_W-1:0]  val_mem  [MAX_DISTINCT];
    logic [WEIGHT_W-1:0] wgt_mem  [MAX_DISTINCT];
    logic [IDX_W-1:0]    cid_mem  [MAX_DISTINCT];
    logic [MEAN_W-1:0]   mean_mem [MAX_DISTINCT];
    logic [VALUE_W-1:0]  rd_val_reg;
    logic [WEIGHT_W-1:0] rd_wgt_reg;
    logic [IDX_W-1:0]    rd_cid_reg;
    logic [MEAN_W-1:0]   rd_mean_reg;

    logic [MAX_DISTINCT-1:0] visited_reg, assigned_reg, pending_reg, emitted_reg;

    logic [VALUE_W-1:0]  center_reg;
    logic [WSUM_W-1:0]   wsum_reg;
    logic [SSUM_W-1:0]   ssum_reg;
    logic [CNT_W-1:0]    n_reg;

    logic [MEAN_W-1:0]   min_reg;
    logic [IDX_W-1:0]    minidx_reg;
    logic                have_reg;
    logic                overflow_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    logic [WEIGHT_W:0]   wgt_sum;
    logic [WEIGHT_W-1:0] wgt_sat, wgt_wdata;
    logic [VALUE_W-1:0]  span;
    logic                near;
    logic [SSUM_W-1:0]   rmin_prod;
    logic                mean_ok;
    logic                core;
    logic                div_busy;
    logic [DVD_W-1:0]    quotient;
    logic                out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= VALUE_W'(8);
            minw_reg   <= VALUE_W'(4);
            lpm_reg    <= 1'b0;
            rmin_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_RADIUS:     radius_reg <= cfg_data;
                CFG_MIN_WEIGHT: minw_reg   <= cfg_data;
                CFG_LOW_PULSE:  lpm_reg    <= cfg_data[0];
                CFG_RESET_MIN:  rmin_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_val_reg <= in_item.sample_value;
            in_wgt_reg <= in_item.sample_weight;
        end
    end

    // Merge weight, saturating at all ones
    assign wgt_sum   = {1'b0, rd_wgt_reg} + (WEIGHT_W + 1)'(in_wgt_reg);
    assign wgt_sat   = wgt_sum[WEIGHT_W] ? '1 : wgt_sum[WEIGHT_W-1:0];
    assign wgt_wdata = cmd.write_entry ? WEIGHT_W'(in_wgt_reg) : wgt_sat;

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry)
        begin
            val_mem[addr] <= in_val_reg;
        end
        rd_val_reg <= val_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry || cmd.write_weight)
        begin
            wgt_mem[addr] <= wgt_wdata;
        end
        rd_wgt_reg <= wgt_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.assign_id)
        begin
            cid_mem[addr] <= cid;
        end
        rd_cid_reg <= cid_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_mean)
        begin
            mean_mem[addr] <= quotient[MEAN_W-1:0];
        end
        rd_mean_reg <= mean_mem[addr];
    end

    assign span = (center_reg >= rd_val_reg) ? (center_reg - rd_val_reg)
                                             : (rd_val_reg - center_reg);
    assign near = span < radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            assigned_reg <= '0;
            pending_reg  <= '0;
            emitted_reg  <= '0;
        end
        else if (cmd.clear_flags)
        begin
            visited_reg  <= '0;
            assigned_reg <= '0;
            pending_reg  <= '0;
            emitted_reg  <= '0;
        end
        else
        begin
            if (cmd.set_visited)
            begin
                visited_reg[addr] <= 1'b1;
            end
            if (cmd.assign_id)
            begin
                assigned_reg[addr] <= 1'b1;
            end
            if (cmd.clear_pending)
            begin
                pending_reg[addr] <= 1'b0;
            end
            // Unvisited or still unclustered neighbors go on the pending list
            if (cmd.mark_eval && near && (!visited_reg[addr] || !assigned_reg[addr]))
            begin
                pending_reg[addr] <= 1'b1;
            end
            if (cmd.em_mark)
            begin
                emitted_reg[minidx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_center)
        begin
            center_reg <= rd_val_reg;
            wsum_reg   <= '0;
            ssum_reg   <= '0;
            n_reg      <= '0;
        end
        else if (cmd.clear_acc)
        begin
            wsum_reg <= '0;
            ssum_reg <= '0;
            n_reg    <= '0;
        end
        else if (cmd.hood_acc && near)
        begin
            wsum_reg <= wsum_reg + WSUM_W'(rd_wgt_reg);
            ssum_reg <= ssum_reg + SSUM_W'(rd_val_reg);
            n_reg    <= n_reg + CNT_W'(1);
        end
        else if (cmd.mean_acc && assigned_reg[addr] && (rd_cid_reg == cid))
        begin
            ssum_reg <= ssum_reg + SSUM_W'(rd_val_reg);
            n_reg    <= n_reg + CNT_W'(1);
        end
    end

    // floor(sum / n) >= rmin  is  sum >= rmin * n  for n > 0
    assign rmin_prod = SSUM_W'(rmin_reg) * SSUM_W'(n_reg);
    assign mean_ok   = (n_reg == '0) ? (rmin_reg == '0) : (ssum_reg >= rmin_prod);
    assign core      = wsum_reg >= WSUM_W'(minw_reg);

    wdbscan_div #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({ssum_reg, {FRAC_W{1'b0}}}),
        .divisor  (n_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            if (cmd.em_clear)
            begin
                have_reg <= 1'b0;
            end
            else if (cmd.em_cmp && !emitted_reg[addr])
            begin
                have_reg <= 1'b1;
            end
            if (cmd.set_overflow)
            begin
                overflow_reg <= 1'b1;
            end
            else if (cmd.clear_overflow)
            begin
                overflow_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.em_cmp && !emitted_reg[addr] && (!have_reg || (rd_mean_reg < min_reg)))
        begin
            min_reg    <= rd_mean_reg;
            minidx_reg <= addr;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out || cmd.load_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_item_reg.cluster_mean_q8 <= min_reg;
            out_item_reg.no_clusters     <= 1'b0;
            out_item_reg.store_overflow  <= overflow_reg;
            out_item_reg.last_result     <= cmd.last;
        end
        else if (cmd.load_none)
        begin
            out_item_reg.cluster_mean_q8 <= '0;
            out_item_reg.no_clusters     <= 1'b1;
            out_item_reg.store_overflow  <= overflow_reg;
            out_item_reg.last_result     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign stat.match    = rd_val_reg == in_val_reg;
    assign stat.visited  = visited_reg[addr];
    assign stat.assigned = assigned_reg[addr];
    assign stat.pending  = pending_reg[addr];
    assign stat.seed_ok  = core || (lpm_reg && mean_ok);
    assign stat.core     = core;
    assign stat.div_busy = div_busy;
    assign stat.out_free = out_free;

endmodule

[rtl/core/wdbscan_ctrl.sv]
// Controller: sequences add merges and new entries, the DBSCAN walk, mean division and sorted emission.
// Depends on wdbscan_pkg.
module wdbscan_ctrl
    import wdbscan_pkg::*;
#(
    parameter int MAX_DISTINCT = DEFAULT_MAX_DISTINCT,
    localparam int IDX_W = $clog2(MAX_DISTINCT),
    localparam int CNT_W = $clog2(MAX_DISTINCT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_action,
    output logic             in_ready,
    input  stat_t            stat,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] addr,
    output logic [IDX_W-1:0] cid
);

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_RD, S_ADD_CHK, S_ADD_NEW,
        S_SC_INIT, S_SC_OUTER, S_HD_CEN, S_HD_RD, S_HD_ACC, S_SC_DECIDE,
        S_MK_RD, S_MK_EVAL, S_EX_START, S_EX_SCAN, S_EX_DECIDE, S_EX_ASSIGN,
        S_MN_START, S_MN_RD, S_MN_ACC, S_MN_DIV, S_MN_WAIT,
        S_EM_START, S_EM_RD, S_EM_CMP, S_EM_OUT, S_EM_NONE, S_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg, idx_reg, ctr_reg, ptr_reg;
    logic [CNT_W-1:0] nclust_reg, clus_reg, k_reg;
    logic             busy_reg, expand_reg;
    logic             idx_end, ptr_end, last_clus, last_emit;

    assign idx_end   = idx_reg == count_reg;
    assign ptr_end   = ptr_reg == count_reg;
    assign last_clus = (clus_reg + CNT_W'(1)) == nclust_reg;
    assign last_emit = (k_reg + CNT_W'(1)) == nclust_reg;
    assign in_ready  = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            ctr_reg    <= '0;
            ptr_reg    <= '0;
            nclust_reg <= '0;
            clus_reg   <= '0;
            k_reg      <= '0;
            busy_reg   <= 1'b0;
            expand_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg   <= '0;
                        state_reg <= in_action ? S_SC_INIT : S_ADD_RD;
                    end
                end
                S_ADD_RD:
                begin
                    state_reg <= idx_end ? S_ADD_NEW : S_ADD_CHK;
                end
                S_ADD_CHK:
                begin
                    if (stat.match)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_ADD_RD;
                    end
                end
                S_ADD_NEW:
                begin
                    if (count_reg < CNT_W'(MAX_DISTINCT))
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= S_IDLE;
                end
                S_SC_INIT:
                begin
                    nclust_reg <= '0;
                    ctr_reg    <= '0;
                    k_reg      <= '0;
                    state_reg  <= S_SC_OUTER;
                end
                S_SC_OUTER:
                begin
                    if (ctr_reg == count_reg)
                    begin
                        clus_reg  <= '0;
                        state_reg <= (nclust_reg == '0) ? S_EM_NONE : S_MN_START;
                    end
                    else if (stat.visited)
                    begin
                        ctr_reg <= ctr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        expand_reg <= 1'b0;
                        state_reg  <= S_HD_CEN;
                    end
                end
                S_HD_CEN:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_HD_RD;
                end
                S_HD_RD:
                begin
                    if (idx_end)
                    begin
                        state_reg <= expand_reg ? S_EX_DECIDE : S_SC_DECIDE;
                    end
                    else
                    begin
                        state_reg <= S_HD_ACC;
                    end
                end
                S_HD_ACC:
                begin
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_HD_RD;
                end
                S_SC_DECIDE:
                begin
                    if (stat.seed_ok && (nclust_reg < CNT_W'(MAX_DISTINCT)))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_MK_RD;
                    end
                    else
                    begin
                        ctr_reg   <= ctr_reg + CNT_W'(1);
                        state_reg <= S_SC_OUTER;
                    end
                end
                S_MK_RD:
                begin
                    if (idx_end)
                    begin
                        state_reg <= expand_reg ? S_EX_ASSIGN : S_EX_START;
                    end
                    else
                    begin
                        state_reg <= S_MK_EVAL;
                    end
                end
                S_MK_EVAL:
                begin
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_MK_RD;
                end
                S_EX_START:
                begin
                    ptr_reg   <= '0;
                    busy_reg  <= 1'b0;
                    state_reg <= S_EX_SCAN;
                end
                S_EX_SCAN:
                begin
                    if (ptr_end)
                    begin
                        if (busy_reg)
                        begin
                            ptr_reg  <= '0;
                            busy_reg <= 1'b0;
                        end
                        else
                        begin
                            nclust_reg <= nclust_reg + CNT_W'(1);
                            ctr_reg    <= ctr_reg + CNT_W'(1);
                            state_reg  <= S_SC_OUTER;
                        end
                    end
                    else if (!stat.pending)
                    begin
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        busy_reg <= 1'b1;
                        if (!stat.visited)
                        begin
                            expand_reg <= 1'b1;
                            state_reg  <= S_HD_CEN;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + CNT_W'(1);
                        end
                    end
                end
                S_EX_DECIDE:
                begin
                    if (stat.core)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_MK_RD;
                    end
                    else
                    begin
                        state_reg <= S_EX_ASSIGN;
                    end
                end
                S_EX_ASSIGN:
                begin
                    ptr_reg   <= ptr_reg + CNT_W'(1);
                    state_reg <= S_EX_SCAN;
                end
                S_MN_START:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_MN_RD;
                end
                S_MN_RD:
                begin
                    state_reg <= idx_end ? S_MN_DIV : S_MN_ACC;
                end
                S_MN_ACC:
                begin
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_MN_RD;
                end
                S_MN_DIV:
                begin
                    state_reg <= S_MN_WAIT;
                end
                S_MN_WAIT:
                begin
                    if (!stat.div_busy)
                    begin
                        clus_reg  <= clus_reg + CNT_W'(1);
                        state_reg <= last_clus ? S_EM_START : S_MN_START;
                    end
                end
                S_EM_START:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_EM_RD;
                end
                S_EM_RD:
                begin
                    state_reg <= (idx_reg == nclust_reg) ? S_EM_OUT : S_EM_CMP;
                end
                S_EM_CMP:
                begin
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_EM_RD;
                end
                S_EM_OUT:
                begin
                    if (stat.out_free)
                    begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= last_emit ? S_FINISH : S_EM_START;
                    end
                end
                S_EM_NONE:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    count_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_ADD_NEW:                          addr = count_reg[IDX_W-1:0];
            S_SC_OUTER, S_SC_DECIDE:            addr = ctr_reg[IDX_W-1:0];
            S_EX_SCAN, S_EX_DECIDE, S_EX_ASSIGN: addr = ptr_reg[IDX_W-1:0];
            S_MN_DIV, S_MN_WAIT:                addr = clus_reg[IDX_W-1:0];
            default:                            addr = idx_reg[IDX_W-1:0];
        endcase
        cid = (state_reg == S_MN_ACC) ? clus_reg[IDX_W-1:0] : nclust_reg[IDX_W-1:0];
    end

    always_comb
    begin
        cmd      = '0;
        cmd.last = last_emit;
        unique case (state_reg)
            S_IDLE:      cmd.latch_in = in_valid;
            S_ADD_CHK:   cmd.write_weight = stat.match;
            S_ADD_NEW:
            begin
                cmd.write_entry  = count_reg < CNT_W'(MAX_DISTINCT);
                cmd.set_overflow = !(count_reg < CNT_W'(MAX_DISTINCT));
            end
            S_SC_INIT:   cmd.clear_flags = 1'b1;
            S_SC_OUTER:  cmd.set_visited = (ctr_reg != count_reg) && !stat.visited;
            S_HD_CEN:    cmd.cap_center = 1'b1;
            S_HD_ACC:    cmd.hood_acc = 1'b1;
            S_SC_DECIDE: cmd.assign_id = stat.seed_ok && (nclust_reg < CNT_W'(MAX_DISTINCT));
            S_MK_EVAL:   cmd.mark_eval = 1'b1;
            S_EX_SCAN:
            begin
                if (!ptr_end && stat.pending)
                begin
                    cmd.clear_pending = 1'b1;
                    cmd.set_visited   = !stat.visited;
                    cmd.assign_id     = stat.visited && !stat.assigned;
                end
            end
            S_EX_ASSIGN: cmd.assign_id = !stat.assigned;
            S_MN_START:  cmd.clear_acc = 1'b1;
            S_MN_ACC:    cmd.mean_acc = 1'b1;
            S_MN_DIV:    cmd.div_start = 1'b1;
            S_MN_WAIT:   cmd.write_mean = !stat.div_busy;
            S_EM_START:  cmd.em_clear = 1'b1;
            S_EM_CMP:    cmd.em_cmp = 1'b1;
            S_EM_OUT:
            begin
                cmd.load_out = stat.out_free;
                cmd.em_mark  = stat.out_free;
            end
            S_EM_NONE:   cmd.load_none = stat.out_free;
            S_FINISH:    cmd.clear_overflow = 1'b1;
            default:     ;
        endcase
    end

endmodule

[tb/weighted_1d_dbscan_cluster_means_top_tb.sv]
// Self-checking testbench for weighted_1d_dbscan_cluster_means_top.
// Holds a predictor of the store and the weighted DBSCAN scan in a scoreboard class.
// Depends on wdbscan_pkg and the RTL of the block only.
module weighted_1d_dbscan_cluster_means_top_tb;
    import wdbscan_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [6:0] NO_OWNER = 7'd127;
    localparam logic [31:0] WEIGHT_SAT = 32'hFFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_SCAN = 1'b1;
    localparam int IDLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 300;

    class cluster_mean_scoreboard;
        logic [15:0] radius;
        logic [15:0] min_weight;
        logic        low_pulse;
        logic [15:0] reset_min;
        logic [15:0] values[DEPTH];
        logic [31:0] weights[DEPTH];
        int unsigned held;
        bit          overflow;
        bit          seen[DEPTH];
        bit          queued[DEPTH];
        logic [6:0]  owner[DEPTH];
        out_item_t   expected_q[$];
        int          errors;
        int          items;
        int          results;
        int          scans;

        function new();
            radius = 16'd8;
            min_weight = 16'd4;
            low_pulse = 1'b0;
            reset_min = 16'd0;
            held = 0;
            overflow = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_RADIUS:     radius = data;
                CFG_MIN_WEIGHT: min_weight = data;
                CFG_LOW_PULSE:  low_pulse = data[0];
                CFG_RESET_MIN:  reset_min = data;
                default: ;
            endcase
        endfunction

        function bit near(int unsigned a, int unsigned b);
            int unsigned d;
            d = (a > b) ? a - b : b - a;
            return d < radius;
        endfunction

        function void hood(int c, output longint unsigned w, output longint unsigned m);
            longint unsigned s;
            longint unsigned n;
            w = 0;
            s = 0;
            n = 0;
            for (int i = 0; i < held; i++)
                if (near(values[c], values[i]))
                begin
                    w += weights[i];
                    s += values[i];
                    n++;
                end
            m = n ? s / n : 0;
        endfunction

        function void mark(int c);
            for (int i = 0; i < held; i++)
                if (near(values[c], values[i]) && (!seen[i] || owner[i] == NO_OWNER))
                    queued[i] = 1;
        endfunction

        function void grow(int seed, logic [6:0] id);
            bit busy;
            longint unsigned w;
            longint unsigned m;
            busy = 1;
            owner[seed] = id;
            mark(seed);
            while (busy)
            begin
                busy = 0;
                for (int i = 0; i < held; i++)
                begin
                    if (!queued[i])
                        continue;
                    queued[i] = 0;
                    busy = 1;
                    if (!seen[i])
                    begin
                        seen[i] = 1;
                        hood(i, w, m);
                        if (w >= min_weight)
                            mark(i);
                    end
                    if (owner[i] == NO_OWNER)
                        owner[i] = id;
                end
            end
        endfunction

        function void scan();
            logic [23:0] means[DEPTH];
            logic [23:0] key;
            longint unsigned w;
            longint unsigned m;
            longint unsigned s;
            longint unsigned n;
            int nclust;
            int k;
            bit noise;
            out_item_t res;
            nclust = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                seen[i] = 0;
                queued[i] = 0;
                owner[i] = NO_OWNER;
            end
            for (int i = 0; i < held; i++)
            begin
                if (seen[i])
                    continue;
                seen[i] = 1;
                hood(i, w, m);
                noise = w < min_weight;
                if (noise && low_pulse)
                    noise = !(m >= reset_min);
                if (!noise && nclust < DEPTH)
                begin
                    grow(i, nclust[6:0]);
                    nclust++;
                end
            end
            for (int j = 0; j < nclust; j++)
            begin
                s = 0;
                n = 0;
                for (int i = 0; i < held; i++)
                    if (owner[i] == j[6:0])
                    begin
                        s += values[i];
                        n++;
                    end
                means[j] = n ? 24'((s << 8) / n) : 24'd0;
            end
            for (int j = 1; j < nclust; j++)
            begin
                key = means[j];
                k = j;
                while (k > 0 && means[k-1] > key)
                begin
                    means[k] = means[k-1];
                    k--;
                end
                means[k] = key;
            end
            if (nclust == 0)
            begin
                res.cluster_mean_q8 = '0;
                res.no_clusters = 1'b1;
                res.store_overflow = overflow;
                res.last_result = 1'b1;
                expected_q = {expected_q, res};
            end
            for (int j = 0; j < nclust; j++)
            begin
                res.cluster_mean_q8 = means[j];
                res.no_clusters = 1'b0;
                res.store_overflow = overflow;
                res.last_result = (j + 1 == nclust);
                expected_q = {expected_q, res};
            end
            held = 0;
            overflow = 0;
            scans++;
        endfunction

        function void note_item(in_item_t it);
            logic [32:0] sum;
            items++;
            if (it.action == ACT_SCAN)
            begin
                scan();
                return;
            end
            for (int i = 0; i < held; i++)
                if (values[i] == it.sample_value)
                begin
                    sum = {1'b0, weights[i]} + it.sample_weight;
                    weights[i] = sum[32] ? WEIGHT_SAT : sum[31:0];
                    return;
                end
            if (held < DEPTH)
            begin
                values[held] = it.sample_value;
                weights[held] = {16'd0, it.sample_weight};
                held++;
            end
            else
                overflow = 1;
        endfunction

        task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            results++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result, mean", got.cluster_mean_q8, 24'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.cluster_mean_q8 !== want.cluster_mean_q8)
                report_mismatch("cluster_mean_q8", got.cluster_mean_q8, want.cluster_mean_q8);
            if (got.no_clusters !== want.no_clusters)
                report_mismatch("no_clusters", got.no_clusters, want.no_clusters);
            if (got.store_overflow !== want.store_overflow)
                report_mismatch("store_overflow", got.store_overflow, want.store_overflow);
            if (got.last_result !== want.last_result)
                report_mismatch("last_result", got.last_result, want.last_result);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cluster_mean_scoreboard sb = new();
    int burst_left;
    int gap_max;
    int stall_pct;
    bit hold_req;
    bit hold_started = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    weighted_1d_dbscan_cluster_means_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_item(in_item);
        if (out_valid && out_ready)
            sb.check_result(out_item);
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req && !hold_started)
        begin
            hold_started = 1;
            hold_left = 2000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [15:0] value, logic [15:0] weight);
        in_item_t it;
        int gap;
        it.action = act;
        it.sample_value = value;
        it.sample_weight = weight;
        if (burst_left <= 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(gap_max) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Drain all results, then let a trailing add finish before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(logic [15:0] rad, logic [15:0] minw, logic lp, logic [15:0] rmin);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_MIN_WEIGHT, minw);
        write_reg(CFG_LOW_PULSE, {15'd0, lp});
        write_reg(CFG_RESET_MIN, rmin);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] rad;
        logic [15:0] minw;
        logic [15:0] rmin;
        logic [15:0] base;
        int adds;
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        burst_left = 0;
        gap_max = 3;
        stall_pct = 20;
        hold_req = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store, then extremes under reset register values.
        send_item(ACT_SCAN, 16'd0, 16'd0);
        send_item(ACT_ADD, 16'd0, 16'hFFFF);
        send_item(ACT_ADD, 16'd0, 16'd0);
        send_item(ACT_ADD, 16'd1, 16'd1);
        send_item(ACT_ADD, 16'hFFFF, 16'd0);
        send_item(ACT_ADD, 16'hFFFE, 16'hFFFF);
        send_item(ACT_ADD, 16'd7, 16'd3);
        send_item(ACT_SCAN, 16'hFFFF, 16'hFFFF);
        settle();

        // Zero radius: empty neighborhoods, low-pulse rule starts singleton clusters.
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_regs(16'd0, 16'hFFFF, 1'b1, 16'd0);
        send_item(ACT_ADD, 16'd100, 16'd1);
        send_item(ACT_ADD, 16'd200, 16'd1);
        send_item(ACT_ADD, 16'd50, 16'd2);
        send_item(ACT_SCAN, 16'd0, 16'd0);
        settle();

        // Widest radius, unreachable weight and mean: no cluster.
        set_regs(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        send_item(ACT_ADD, 16'd10, 16'd1);
        send_item(ACT_ADD, 16'd20, 16'd1);
        send_item(ACT_SCAN, 16'd0, 16'd0);
        settle();

        // Full store: one extra distinct value overflows, a held one still merges.
        set_regs(16'd8, 16'd1, 1'b0, 16'd0);
        for (int i = 0; i <= DEPTH; i++)
            send_item(ACT_ADD, 16'(i * 20), 16'd1);
        send_item(ACT_ADD, 16'd0, 16'd5);
        send_item(ACT_SCAN, 16'd0, 16'd0);
        settle();

        // Random phases: mostly clustered values around a few centers.
        while (sb.items < 110)
        begin
            case ($urandom_range(4))
                0: rad = 16'd1;
                1: rad = 16'hFFFF;
                default: rad = 16'($urandom_range(2, 64));
            endcase
            case ($urandom_range(4))
                0: minw = 16'd1;
                1: minw = 16'hFFFF;
                default: minw = 16'($urandom_range(1, 30));
            endcase
            case ($urandom_range(3))
                0: rmin = 16'd0;
                1: rmin = 16'hFFFF;
                default: rmin = 16'($urandom);
            endcase
            set_regs(rad, minw, 1'($urandom), rmin);
            gap_max = $urandom_range(2) == 0 ? 0 : $urandom_range(1, 8);
            stall_pct = $urandom_range(3) == 0 ? 0 : $urandom_range(10, 80);
            adds = $urandom_range(1, 12);
            base = 16'($urandom);
            for (int i = 0; i < adds; i++)
            begin
                if ($urandom_range(5) == 0)
                    send_item(ACT_ADD, 16'($urandom), 16'($urandom));
                else
                begin
                    if ($urandom_range(3) == 0)
                        base = 16'($urandom);
                    send_item(ACT_ADD, base + 16'($urandom_range(rad > 16 ? 16 : rad)),
                              16'($urandom_range(1, 6)));
                end
            end
            send_item(ACT_SCAN, 16'($urandom), 16'($urandom));
            if (!hold_req)
            begin
                // Hold the receiver off and keep offering items while results wait
                hold_req = 1;
                send_item(ACT_SCAN, 16'd0, 16'd0);
                send_item(ACT_ADD, 16'd1000, 16'd1);
            end
            else if ($urandom_range(2) == 0)
                send_item(ACT_SCAN, 16'd0, 16'd0);
            settle();
        end

        $display("covered %0d items in %0d scans, %0d results checked, %0d mismatches",
                 sb.items, sb.scans, sb.results, sb.errors);
        $display("store overflow, zero and full radius, low-pulse mode, long output stall");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
